@@ src/wsf_pkg.sv @@
// Shared constants for the waypoint step follower.
package wsf_pkg;

  localparam int unsigned MaxWaypoints = 32;
  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned CountWidth   = 6;
  localparam int unsigned DistWidth    = 15;
  localparam int unsigned SlotWidth    = 5;
  localparam int unsigned QuatWidth    = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 15;

  localparam logic [CfgIdxWidth-1:0] CfgWaypointCount   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgArriveThreshold = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStepLength      = 2'd2;

  localparam logic [DistWidth-1:0] ArriveThresholdReset = 15'd64;
  localparam logic [DistWidth-1:0] StepLengthReset      = 15'd26;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTick = 1'b1;

endpackage

@@ src/wsf_req_if.sv @@
// Input item channel, output step channel and configuration write channel.
interface wsf_req_if #(
  parameter int unsigned CoordW = 16
);
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [4:0]               entry_index;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [15:0]       quat_x;
  logic signed [15:0]       quat_y;
  logic signed [15:0]       quat_z;
  logic signed [15:0]       quat_w;

  modport source (output valid, req_type, entry_index, pos_x, pos_y,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, req_type, entry_index, pos_x, pos_y,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface wsf_rsp_if #(
  parameter int unsigned CoordW = 16
);
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] step_x;
  logic signed [CoordW-1:0] step_y;
  logic signed [15:0]       out_quat_x;
  logic signed [15:0]       out_quat_y;
  logic signed [15:0]       out_quat_z;
  logic signed [15:0]       out_quat_w;
  logic signed [CoordW-1:0] target_x;
  logic signed [CoordW-1:0] target_y;
  logic [4:0]               target_slot;

  modport source (output valid, step_x, step_y, out_quat_x, out_quat_y, out_quat_z,
                  out_quat_w, target_x, target_y, target_slot, input ready);
  modport sink   (input valid, step_x, step_y, out_quat_x, out_quat_y, out_quat_z,
                  out_quat_w, target_x, target_y, target_slot, output ready);
endinterface

interface wsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/wsf_ram.sv @@
// Generic single-port RAM with registered read.
module wsf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ src/wsf_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
module wsf_sqrt #(
  parameter int unsigned InWidth = 34
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [InWidth-1:0]        rad_i,
  output logic                      done_o,
  output logic [InWidth/2:0]        root_o
);
  localparam int unsigned RootW = InWidth / 2 + 1;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW+1:0] trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      rad_d  = RadW'(rad_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // bring down two bits, try root*4+1
      rem_d = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
      rad_d = {rad_q[RadW-3:0], 2'b00};
      trial = {root_q, 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign root_o = root_d;
endmodule

@@ src/wsf_div.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
module wsf_div #(
  parameter int unsigned NumWidth = 52,
  parameter int unsigned DenWidth = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output logic                done_o,
  output logic [NumWidth-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] quot_q, quot_d;
  logic [DenWidth:0]   rem_q, rem_d;
  logic [DenWidth-1:0] den_q, den_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [DenWidth:0]   shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = '0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shifted = {rem_q[DenWidth-1:0], quot_q[NumWidth-1]};
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_d;
endmodule

@@ src/waypoint_step_follower.sv @@
// Waypoint step follower: waypoint table in RAM, sequential distance and step.
// A tick that stands still or lands on the target skips the arithmetic; else the
// bit-serial root and then the two divides run. One item at a time; the output
// register lets the next item enter while a result waits. Reset clears the slot,
// the configuration registers and the output valid, not the table.
module waypoint_step_follower #(
  parameter int unsigned MAX_WAYPOINTS = wsf_pkg::MaxWaypoints,
  parameter int unsigned COORD_WIDTH   = wsf_pkg::CoordWidth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  wsf_req_if.sink   req,
  wsf_rsp_if.source rsp,
  wsf_cfg_if.sink   cfg
);
  import wsf_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = CW + 1;          // difference width
  localparam int unsigned SqW   = 2 * DW + 1;      // sum of squares
  localparam int unsigned RootW = SqW / 2 + 1;
  localparam int unsigned NumW  = DW + DistWidth + 2;
  localparam int unsigned CntLim = (MAX_WAYPOINTS > 63) ? 63 : MAX_WAYPOINTS;

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StRead  = 10'b0000000010,
    StDist1 = 10'b0000000100,
    StRead2 = 10'b0000001000,
    StDist2 = 10'b0000010000,
    StSqrt  = 10'b0000100000,
    StDivX  = 10'b0001000000,
    StDivY  = 10'b0010000000,
    StOut   = 10'b0100000000,
    StPad   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CountWidth-1:0] count_q;
  logic [DistWidth-1:0]  thr_q, step_q;
  logic [AddrW-1:0]      slot_q, slot_d;
  logic                  slot_hi_q, slot_hi_d;   // slot counter past AddrW bits
  logic signed [CW-1:0]  cx_q, cy_q;
  logic [15:0]           qx_q, qy_q, qz_q, qw_q;
  logic signed [DW-1:0]  dx_q, dy_q;
  logic [NumW-1:0]       offx_q;
  logic [RootW-1:0]      dist_q;
  logic                  ovalid_q;
  logic signed [CW-1:0]  osx_q, osy_q;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_addr;
  logic [2*CW-1:0]       ram_wdata, ram_rdata;
  logic signed [CW-1:0]  tx, ty;

  wsf_ram #(.Width(2 * CW), .Depth(MAX_WAYPOINTS)) u_table (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign tx = ram_rdata[2*CW-1:CW];
  assign ty = ram_rdata[CW-1:0];

  // effective count and full-width current slot
  logic [CountWidth:0] count_eff;
  assign count_eff = (CountWidth+1)'((count_q > CountWidth'(CntLim)) ? CountWidth'(CntLim)
                                                                        : count_q);
  logic [CountWidth:0] slot_full;
  assign slot_full = slot_hi_q ? (CountWidth+1)'(MAX_WAYPOINTS)
                               : (CountWidth+1)'(slot_q);

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == StIdle);

  logic acc;
  assign acc = req.valid && req.ready;

  // squares
  logic [SqW-1:0] sq_x, sq_y, d2_new;
  logic [DW-1:0]  adx, ady;
  assign adx    = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ady    = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign sq_x   = SqW'(adx) * SqW'(adx);
  assign sq_y   = SqW'(ady) * SqW'(ady);
  assign d2_new = sq_x + sq_y;

  logic [SqW-1:0] thr_sq, step_sq;
  assign thr_sq  = SqW'(thr_q) * SqW'(thr_q);
  assign step_sq = SqW'(step_q) * SqW'(step_q);

  // sqrt and divide units
  logic             sq_start, sq_done;
  logic [RootW-1:0] root;
  wsf_sqrt #(.InWidth(2 * RootW - 2)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i((2*RootW-2)'(d2_new)),
    .done_o(sq_done), .root_o(root)
  );

  logic            dv_start, dv_done, dv_sel_y;
  logic [NumW-1:0] dv_num, quot;
  logic [DW-1:0]   dmag;
  assign dmag   = dv_sel_y ? ady : adx;
  // (|d|*step*2 + dist) / (dist*2)
  assign dv_num = NumW'(NumW'(dmag) * NumW'(step_q) * NumW'(2)) + NumW'(dist_q);
  wsf_div #(.NumWidth(NumW), .DenWidth(RootW + 1)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i({dist_q, 1'b0}),
    .done_o(dv_done), .quot_o(quot)
  );

  // saturated step coordinate from current point and offset
  function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] c,
                                                 logic neg, logic [NumW-1:0] mag);
    logic signed [NumW+1:0] s;
    logic signed [NumW+1:0] hi, lo;
    hi = (NumW+2)'((1 << (CW - 1)) - 1);
    lo = -hi - 1;
    s  = (NumW+2)'(c) + (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
    if (s > hi) begin
      return hi[CW-1:0];
    end else if (s < lo) begin
      return lo[CW-1:0];
    end
    return s[CW-1:0];
  endfunction

  logic pass;
  logic signed [CW-1:0] osx_d, osy_d;
  logic                 out_load;

  // divider handshake: a start is issued once per division
  logic u_div_busy, div_started_q;
  assign u_div_busy = div_started_q;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    slot_hi_d = slot_hi_q;
    ram_we    = 1'b0;
    ram_addr  = slot_q;
    ram_wdata = {req.pos_x, req.pos_y};
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    dv_sel_y  = (state_q == StDivY);
    osx_d     = osx_q;
    osy_d     = osy_q;
    out_load  = 1'b0;
    pass      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (req.req_type == ReqLoad) begin
            ram_addr = AddrW'(req.entry_index);
            ram_we   = (32'(req.entry_index) < MAX_WAYPOINTS);
          end else if (count_eff != '0 && slot_full < count_eff) begin
            state_d = StRead;
          end
        end
      end
      StRead:  state_d = StDist1;
      StDist1: begin
        // distance squared is combinational from the registered diffs, used in StRead2
        state_d = StRead2;
      end
      StRead2: begin
        if (d2_new < thr_sq && slot_full < count_eff - 1'b1) begin
          {slot_hi_d, slot_d} = (AddrW+1)'({slot_hi_q, slot_q}) + 1'b1;
          ram_addr = AddrW'(slot_q + 1'b1);
        end
        state_d = StDist2;
      end
      StDist2: state_d = StPad;
      StPad: begin
        if (d2_new == '0) begin
          osx_d = cx_q; osy_d = cy_q; pass = 1'b1;
        end else if (step_sq >= d2_new) begin
          osx_d = tx; osy_d = ty; pass = 1'b1;
        end else begin
          sq_start = 1'b1;
          state_d  = StSqrt;
        end
        if (pass) state_d = StOut;
      end
      StSqrt: begin
        if (sq_done) state_d = StDivX;
      end
      StDivX: begin
        if (!u_div_busy) dv_start = 1'b1;
        if (dv_done) state_d = StDivY;
      end
      StDivY: begin
        if (!u_div_busy) dv_start = 1'b1;
        if (dv_done) begin
          osx_d   = sat_add(cx_q, dx_q[DW-1], offx_q);
          osy_d   = sat_add(cy_q, dy_q[DW-1], quot);
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovalid_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      slot_q        <= '0;
      slot_hi_q     <= 1'b0;
      count_q       <= '0;
      thr_q         <= ArriveThresholdReset;
      step_q        <= StepLengthReset;
      ovalid_q      <= 1'b0;
      div_started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      slot_hi_q <= slot_hi_d;
      if (dv_start) begin
        div_started_q <= 1'b1;
      end else if (dv_done) begin
        div_started_q <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          CfgWaypointCount:   count_q <= cfg.data[CountWidth-1:0];
          CfgArriveThreshold: thr_q   <= cfg.data;
          CfgStepLength:      step_q  <= cfg.data;
          default: ;
        endcase
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (rsp.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cx_q <= req.pos_x;
      cy_q <= req.pos_y;
      qx_q <= req.quat_x;
      qy_q <= req.quat_y;
      qz_q <= req.quat_z;
      qw_q <= req.quat_w;
    end
    if (state_q == StRead || state_q == StDist2) begin
      dx_q <= DW'(tx) - DW'(cx_q);
      dy_q <= DW'(ty) - DW'(cy_q);
    end
    if (sq_done) dist_q <= root;
    if (state_q == StDivX && dv_done) offx_q <= quot;
    osx_q <= osx_d;
    osy_q <= osy_d;
    if (out_load) begin
      rsp.step_x      <= osx_q;
      rsp.step_y      <= osy_q;
      rsp.out_quat_x  <= qx_q;
      rsp.out_quat_y  <= qy_q;
      rsp.out_quat_z  <= qz_q;
      rsp.out_quat_w  <= qw_q;
      rsp.target_x    <= tx;
      rsp.target_y    <= ty;
      rsp.target_slot <= 5'(slot_q);
    end
  end

  assign rsp.valid = ovalid_q;
endmodule

@@ bench/tb_waypoint_step_follower.sv @@
// Self-checking testbench for the waypoint step follower.
module tb_waypoint_step_follower;
  import wsf_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 200;
  localparam int LongHold      = 400;

  typedef struct packed {
    logic [15:0] step_x;
    logic [15:0] step_y;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [4:0]  slot;
  } step_result_t;

  logic clk_i;
  logic rst_ni;

  wsf_req_if #(.CoordW(CoordWidth)) req_ch ();
  wsf_rsp_if #(.CoordW(CoordWidth)) rsp_ch ();
  wsf_cfg_if                        cfg_ch ();

  waypoint_step_follower DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // Mirror of the block state
  longint       wp_x [MaxWaypoints];
  longint       wp_y [MaxWaypoints];
  int unsigned  cur_slot;
  int unsigned  wp_count;
  longint       arrive_dist;
  longint       step_len;
  longint       last_step_x;
  longint       last_step_y;

  step_result_t expected_steps[$];
  int           mismatches   = 0;
  int           steps_seen   = 0;
  int           ticks_sent;
  int           loads_sent;
  int           quiet_cycles = 0;
  bit           no_gaps;
  bit           hold_req;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_offset(longint d, longint unsigned root_v);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q   = (mag * longint'(step_len) * 2 + root_v) / (root_v * 2);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Apply one accepted item to the mirror and queue its step, if any
  task automatic predict_item(logic rtype, logic [4:0] idx, logic signed [15:0] px,
                              logic signed [15:0] py, logic [15:0] qx, logic [15:0] qy,
                              logic [15:0] qz, logic [15:0] qw);
    int unsigned     cnt;
    int unsigned     slot;
    longint          cx, cy, tx, ty, dx, dy, sx, sy;
    longint unsigned d2, root_v;
    step_result_t    r;
    cx = px;
    cy = py;
    if (rtype == ReqLoad) begin
      wp_x[idx] = cx;
      wp_y[idx] = cy;
      loads_sent++;
      return;
    end
    ticks_sent++;
    cnt = (wp_count > MaxWaypoints) ? MaxWaypoints : wp_count;
    if (cnt == 0 || cur_slot >= cnt) return;
    slot = cur_slot;
    dx = wp_x[slot] - cx;
    dy = wp_y[slot] - cy;
    d2 = dx * dx + dy * dy;
    if (d2 < arrive_dist * arrive_dist && slot < cnt - 1) begin
      slot++;
      cur_slot = slot;
    end
    tx = wp_x[slot];
    ty = wp_y[slot];
    dx = tx - cx;
    dy = ty - cy;
    d2 = dx * dx + dy * dy;
    if (d2 == 0) begin
      sx = cx;
      sy = cy;
    end else if (step_len * step_len >= d2) begin
      sx = tx;
      sy = ty;
    end else begin
      root_v = isqrt(d2);
      sx = clamp_coord(cx + scale_offset(dx, root_v));
      sy = clamp_coord(cy + scale_offset(dy, root_v));
    end
    last_step_x = sx;
    last_step_y = sy;
    r.step_x   = sx[15:0];
    r.step_y   = sy[15:0];
    r.quat_x   = qx;
    r.quat_y   = qy;
    r.quat_z   = qz;
    r.quat_w   = qw;
    r.target_x = tx[15:0];
    r.target_y = ty[15:0];
    r.slot     = slot[4:0];
    expected_steps.insert(expected_steps.size(), r);
  endtask

  task automatic send_item(logic rtype, logic [4:0] idx, logic signed [15:0] px,
                           logic signed [15:0] py, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, logic [15:0] qw);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rtype;
    req_ch.entry_index <= idx;
    req_ch.pos_x       <= px;
    req_ch.pos_y       <= py;
    req_ch.quat_x      <= qx;
    req_ch.quat_y      <= qy;
    req_ch.quat_z      <= qz;
    req_ch.quat_w      <= qw;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_item(rtype, idx, px, py, qx, qy, qz, qw);
  endtask

  task automatic send_load(int idx, int px, int py);
    send_item(ReqLoad, 5'(idx), 16'(px), 16'(py), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_tick(int px, int py);
    send_item(ReqTick, 5'($urandom), 16'(px), 16'(py), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  // Drain outstanding steps, then let any silent tick finish before touching registers
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, int data);
    logic [CfgDataWidth-1:0] d;
    d = CfgDataWidth'(data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgWaypointCount:   wp_count    = d[CountWidth-1:0];
      CfgArriveThreshold: arrive_dist = d;
      CfgStepLength:      step_len    = d;
      default: ;
    endcase
  endtask

  task automatic set_regs(int cnt, int thr, int stp);
    settle();
    write_reg(CfgWaypointCount, cnt);
    write_reg(CfgArriveThreshold, thr);
    write_reg(CfgStepLength, stp);
  endtask

  // Tick with a zero count after reset, then fill every slot so no unloaded entry is ever read
  task automatic test_reset_and_fill();
    send_tick(16'sh0100, -16'sh0100);
    send_load(0, 16'sh7fff, 16'sh7fff);
    send_load(1, -16'sh8000, -16'sh8000);
    send_load(2, 16'sh0000, 16'sh0000);
    send_load(3, 16'sh0010, -16'sh0010);
    for (int i = 4; i < MaxWaypoints; i++) send_load(i, $urandom, $urandom);
  endtask

  task automatic test_directed();
    // reset threshold and step; the first tick arrives at slot 0 and advances to the far slot 1, so only partial steps
    settle();
    write_reg(CfgWaypointCount, 2);
    send_tick(16'sh7fff, 16'sh7fff);
    send_tick(16'sh7ff0, 16'sh7fff);
    send_tick(-16'sh8000, 16'sh7fff);
    // zero step length: stand still
    set_regs(2, 0, 0);
    send_tick(16'sh0000, 16'sh0000);
    send_tick(16'sh7fff, 16'sh7fff);
    // huge threshold and step: steps across the full range
    set_regs(4, 32767, 32767);
    send_item(ReqTick, 5'd0, 16'sh7fff, 16'sh7fff, 16'h7fff, 16'h8000, 16'hffff, 16'h0000);
    send_item(ReqTick, 5'd0, 16'sh7fff, 16'sh7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    send_tick(16'sh0000, 16'sh0000);
    send_tick(16'sh0010, -16'sh0010);
    send_tick(16'sh0010, -16'sh0010);
    // count lowered to just above the pursued slot: ticks still step
    set_regs(2, 64, 26);
    send_tick(16'sh0000, 16'sh0000);
    send_tick(16'sh0100, 16'sh0100);
    // count with stray upper data bits, and above the table size
    settle();
    write_reg(CfgWaypointCount, 15'h7fc0 | 15'd4);
    send_tick(16'sh0000, 16'sh0000);
    set_regs(63, 32767, 100);
    send_tick(16'sh0000, 16'sh0000);
    send_tick(16'sh0000, 16'sh0000);
  endtask

  // Fly a fresh route, feeding each step back as the next position
  task automatic fly_route(int n_wp, int n_ticks);
    longint px, py;
    set_regs(0, 0, 0);
    for (int i = 0; i < n_wp; i++)
      send_load(i, $signed(16'($urandom_range(0, 16000))) - 16'sd8000,
                $signed(16'($urandom_range(0, 16000))) - 16'sd8000);
    // go back to slot zero is impossible; start where the mirror already is
    settle();
    write_reg(CfgWaypointCount, ($urandom_range(0, 7) == 0) ? 63 : MaxWaypoints);
    write_reg(CfgArriveThreshold, $urandom_range(100, 2000));
    write_reg(CfgStepLength, $urandom_range(50, 3000));
    px = $signed(16'($urandom));
    py = $signed(16'($urandom));
    for (int t = 0; t < n_ticks; t++) begin
      case ($urandom_range(0, 9))
        0: send_tick($urandom, $urandom);
        1: send_load($urandom, $urandom, $urandom);
        default: begin
          send_tick(px[15:0], py[15:0]);
          px = clamp_coord(last_step_x + $signed($urandom_range(0, 20)) - 10);
          py = clamp_coord(last_step_y + $signed($urandom_range(0, 20)) - 10);
        end
      endcase
    end
  endtask

  task automatic test_random_routes();
    for (int phase = 0; phase < 9; phase++) begin
      no_gaps = (phase % 4 == 3);
      fly_route(MaxWaypoints, 60);
    end
    no_gaps = 1'b0;
    // fully random fields under random settings, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      set_regs($urandom_range(0, 63), (phase == 0) ? 32767 : $urandom,
               (phase == 1) ? 32767 : $urandom);
      for (int t = 0; t < 40; t++)
        if ($urandom_range(0, 3) == 0) send_load($urandom, $urandom, $urandom);
        else send_tick($urandom, $urandom);
    end
  endtask

  task automatic test_backpressure();
    set_regs(MaxWaypoints, 1000, 200);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    for (int t = 0; t < 30; t++) send_tick($urandom, $urandom);
    no_gaps = 1'b0;
  endtask

  // Result receiver with random stalls and one long hold-off on request
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    rsp_ch.ready   = 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall;
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      if (hold_req && !long_hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("step %0d %s: expected %h, got %h", steps_seen, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      step_result_t e;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected step item at %0t", $realtime);
      end else begin
        e = expected_steps.pop_front();
        check_field("step_x", e.step_x, rsp_ch.step_x);
        check_field("step_y", e.step_y, rsp_ch.step_y);
        check_field("quat_x", e.quat_x, rsp_ch.out_quat_x);
        check_field("quat_y", e.quat_y, rsp_ch.out_quat_y);
        check_field("quat_z", e.quat_z, rsp_ch.out_quat_z);
        check_field("quat_w", e.quat_w, rsp_ch.out_quat_w);
        check_field("target_x", e.target_x, rsp_ch.target_x);
        check_field("target_y", e.target_y, rsp_ch.target_y);
        check_field("target_slot", 16'(e.slot), 16'(rsp_ch.target_slot));
      end
      steps_seen++;
    end
  end

  // Watchdog: too long with no item moving on any channel
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = ReqLoad;
    req_ch.entry_index = '0;
    req_ch.pos_x       = '0;
    req_ch.pos_y       = '0;
    req_ch.quat_x      = '0;
    req_ch.quat_y      = '0;
    req_ch.quat_z      = '0;
    req_ch.quat_w      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CfgWaypointCount;
    cfg_ch.data        = '0;
    ticks_sent         = 0;
    loads_sent         = 0;
    no_gaps            = 1'b0;
    hold_req           = 1'b0;
    cur_slot           = 0;
    wp_count           = 0;
    arrive_dist        = ArriveThresholdReset;
    step_len           = StepLengthReset;
    for (int i = 0; i < MaxWaypoints; i++) begin
      wp_x[i] = 0;
      wp_y[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_fill();
    test_directed();
    test_random_routes();
    test_backpressure();

    settle();
    $display("Sent %0d ticks and %0d loads; checked %0d step items", ticks_sent,
             loads_sent, steps_seen);
    $display("Covered routes, silent ticks, register extremes and a long output stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wsf_pkg.sv
src/wsf_req_if.sv
src/wsf_ram.sv
src/wsf_sqrt.sv
src/wsf_div.sv
src/waypoint_step_follower.sv
bench/tb_waypoint_step_follower.sv
